// ===== hdl/sha256_byte_stream_hasher_unit_macros.svh =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher assertion macros
// Shared helpers for the concurrent checks on the hasher's ports.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHBS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hasher check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define SHBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hasher check failed in the following cycle");

`endif

// ===== hdl/shbs_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Types, command and status bundles, and the constant tables of SHA-256.
// ----------------------------------------------------------------------------
`default_nettype none

package shbs_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // Source of the byte written into the block buffer.
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      write_byte;
    byte_sel_t byte_sel;
    logic      count_byte;
    logic      start_round;
    logic      round_en;
    logic      fold;
    logic      next_out;
    logic      clear_msg;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
    logic       out_last;
  } status_t;

  localparam logic       OP_FINISH = 1'b1;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [2:0] LEN_ROW   = 3'd7;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd7;

  // Initial hash words.
  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Round constants.
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] v;
    unique case (idx)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/shbs_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher datapath
// Block buffer and schedule window, round unit, chain value, byte counters
// and digest word selection, all driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module shbs_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire shbs_pkg::cmd_t  cmd,
  input  wire logic [7:0]      data_byte,
  output shbs_pkg::status_t    status,
  output logic [31:0]          digest_word,
  output logic [2:0]           word_index,
  output logic                 last_word
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [5:0]  fill;
  logic [63:0] byte_total;
  logic [31:0] chain [8];
  logic [31:0] window [16];
  logic [31:0] vars [8];
  logic [5:0]  round;
  logic [2:0]  out_idx;

  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [7:0]  wr_byte;
  logic [31:0] sum1, choose, t1, sum0, major, t2, w_new;

  // Byte to store: message byte, padding marker, zero or length byte.
  assign bit_len  = {byte_total[60:0], 3'b000};
  assign len_byte = bit_len[{~fill[2:0], 3'b000} +: 8];

  always_comb begin
    unique case (cmd.byte_sel)
      shbs_pkg::SEL_DATA: wr_byte = data_byte;
      shbs_pkg::SEL_PAD:  wr_byte = shbs_pkg::PAD_BYTE;
      shbs_pkg::SEL_ZERO: wr_byte = 8'h00;
      shbs_pkg::SEL_LEN:  wr_byte = len_byte;
      default:            wr_byte = 8'h00;
    endcase
  end

  // One compression round, plus the next schedule word.
  always_comb begin
    sum1   = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
    choose = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    t1     = vars[7] + sum1 + choose + shbs_pkg::round_k(round) + window[0];
    sum0   = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
    major  = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t2     = sum0 + major;
    w_new  = window[0]
           + (rotr(window[1], 7) ^ rotr(window[1], 18) ^ (window[1] >> 3))
           + window[9]
           + (rotr(window[14], 17) ^ rotr(window[14], 19) ^ (window[14] >> 10));
  end

  // Fill count and message byte count.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_msg) begin
      fill       <= '0;
      byte_total <= '0;
    end else begin
      if (cmd.write_byte) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count_byte) begin
        byte_total <= byte_total + 64'd1;
      end
    end
  end

  // Chain value: initial words at reset and after each digest, fold after rounds.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_msg) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= shbs_pkg::iv_word(3'(i));
      end
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + vars[i];
      end
    end
  end

  // Schedule window: bytes land big-endian, rounds shift it down by one word.
  always_ff @(posedge clk) begin
    if (cmd.write_byte) begin
      window[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= wr_byte;
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        window[i] <= window[i + 1];
      end
      window[15] <= w_new;
    end
  end

  // Working variables a through h.
  always_ff @(posedge clk) begin
    if (cmd.start_round) begin
      for (int i = 0; i < 8; i++) begin
        vars[i] <= chain[i];
      end
    end else if (cmd.round_en) begin
      for (int i = 1; i < 8; i++) begin
        vars[i] <= vars[i - 1];
      end
      vars[4] <= vars[3] + t1;
      vars[0] <= t1 + t2;
    end
  end

  // Round counter and digest word index.
  always_ff @(posedge clk) begin
    if (rst) begin
      round   <= '0;
      out_idx <= '0;
    end else begin
      if (cmd.start_round) begin
        round <= '0;
      end else if (cmd.round_en) begin
        round <= round + 6'd1;
      end
      if (cmd.clear_msg) begin
        out_idx <= '0;
      end else if (cmd.next_out) begin
        out_idx <= out_idx + 3'd1;
      end
    end
  end

  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == shbs_pkg::WORD_LAST);

  assign status.fill       = fill;
  assign status.round_last = (round == shbs_pkg::ROUND_LAST);
  assign status.out_last   = (out_idx == shbs_pkg::WORD_LAST);

endmodule

`default_nettype wire

// ===== hdl/shbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher controller
// Sequences byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module shbs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              opcode,
  input  wire logic              out_ready,
  input  wire shbs_pkg::status_t status,
  output logic                   in_ready,
  output logic                   out_valid,
  output shbs_pkg::cmd_t         cmd
);

  shbs_pkg::state_t state, state_next;
  logic finishing, finishing_next;
  logic wrap, wrap_next;
  logic len_done, len_done_next;
  logic block_full;
  logic len_row;

  assign block_full = (status.fill == shbs_pkg::FILL_LAST);
  assign len_row    = (status.fill[5:3] == shbs_pkg::LEN_ROW);

  // State and padding flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= shbs_pkg::ST_IDLE;
      finishing <= 1'b0;
      wrap      <= 1'b0;
      len_done  <= 1'b0;
    end else begin
      state     <= state_next;
      finishing <= finishing_next;
      wrap      <= wrap_next;
      len_done  <= len_done_next;
    end
  end

  // Next state. The wrap flag marks a padding marker that left no room for the
  // length, so the current block is closed with zeros and one more follows.
  always_comb begin
    state_next     = state;
    finishing_next = finishing;
    wrap_next      = wrap;
    len_done_next  = len_done;
    unique case (state)
      shbs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (opcode == shbs_pkg::OP_FINISH) begin
            finishing_next = 1'b1;
            wrap_next      = len_row && !block_full;
            state_next     = block_full ? shbs_pkg::ST_ROUND : shbs_pkg::ST_PAD;
          end else if (block_full) begin
            state_next = shbs_pkg::ST_ROUND;
          end
        end
      end
      shbs_pkg::ST_PAD: begin
        if (block_full) begin
          state_next = shbs_pkg::ST_ROUND;
          wrap_next  = 1'b0;
          if (!wrap) begin
            len_done_next = 1'b1;
          end
        end
      end
      shbs_pkg::ST_ROUND: begin
        if (status.round_last) begin
          state_next = shbs_pkg::ST_FOLD;
        end
      end
      shbs_pkg::ST_FOLD: begin
        priority if (!finishing) begin
          state_next = shbs_pkg::ST_IDLE;
        end else if (len_done) begin
          state_next = shbs_pkg::ST_EMIT;
        end else begin
          state_next = shbs_pkg::ST_PAD;
        end
      end
      shbs_pkg::ST_EMIT: begin
        if (out_ready && status.out_last) begin
          state_next     = shbs_pkg::ST_IDLE;
          finishing_next = 1'b0;
          wrap_next      = 1'b0;
          len_done_next  = 1'b0;
        end
      end
      default: begin
        state_next = shbs_pkg::ST_IDLE;
      end
    endcase
  end

  // Handshakes and datapath commands.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      shbs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.write_byte  = 1'b1;
          cmd.byte_sel    = (opcode == shbs_pkg::OP_FINISH) ? shbs_pkg::SEL_PAD
                                                            : shbs_pkg::SEL_DATA;
          cmd.count_byte  = (opcode != shbs_pkg::OP_FINISH);
          cmd.start_round = block_full;
        end
      end
      shbs_pkg::ST_PAD: begin
        cmd.write_byte  = 1'b1;
        cmd.byte_sel    = (wrap || !len_row) ? shbs_pkg::SEL_ZERO : shbs_pkg::SEL_LEN;
        cmd.start_round = block_full;
      end
      shbs_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
      end
      shbs_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
      end
      shbs_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.next_out  = 1'b1;
          cmd.clear_msg = status.out_last;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/sha256_byte_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream with SHA-256 and returns the eight digest words.
// ----------------------------------------------------------------------------
// A message byte is taken whenever the block is idle. The byte that completes
// a 64-byte block starts a compression in which no input is taken: the 64
// rounds run on the single round unit, and then the result is added into the
// chain value. A finish request writes the padding one byte per cycle through
// the same path, then runs one or two compressions, and presents the digest
// words 0 to 7 one per cycle as they are taken; no new request is taken until
// the eighth word has gone. After that the block starts the next message from
// the initial hash value. There is no clearing pass after reset.
`default_nettype none

module sha256_byte_stream_hasher_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  shbs_pkg::cmd_t    cmd;
  shbs_pkg::status_t status;

  // Sequencing.
  shbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  shbs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .status      (status),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule

`default_nettype wire

// ===== hdl/shbs_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher checker
// Port-level checks on request intake and digest word ordering.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_byte_stream_hasher_unit_macros.svh"

module shbs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       opcode,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] word_index,
  input wire logic       last_word
);

  // No request is taken while digest words are pending.
  `SHBS_ASSERT_SAME(no_intake_during_output, out_valid, !in_ready)

  // The last word flag marks exactly the eighth word.
  `SHBS_ASSERT_SAME(last_flag_matches_index, out_valid, last_word == (word_index == 3'd7))

  // After a word other than the last is taken, the next one follows at once.
  `SHBS_ASSERT_NEXT(words_in_order, out_valid && out_ready && !last_word, out_valid && (word_index == ($past(word_index) + 3'd1)))

  // Taking the last word ends the output.
  `SHBS_ASSERT_NEXT(output_ends_after_last, out_valid && out_ready && last_word, !out_valid)

  // An absorbed byte never starts output.
  `SHBS_ASSERT_NEXT(absorb_gives_no_output, in_valid && in_ready && !opcode, !out_valid)

endmodule

bind sha256_byte_stream_hasher_unit shbs_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .opcode     (opcode),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .word_index (word_index),
  .last_word  (last_word)
);

`default_nettype wire

// ===== test/sha256_byte_stream_hasher_unit_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher checker
// Watches both channels, keeps its own SHA-256 model of the message stream
// and compares every digest word the block returns with the predicted one.
// ----------------------------------------------------------------------------

module sha256_byte_stream_hasher_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          fail_count,
  output int          pending_words,
  output int          words_checked,
  output int          digests_done,
  output int          blocks_hashed
);

  timeunit 1ns;
  timeprecision 1ps;

  // Initial hash value and round constants of SHA-256.
  localparam logic [0:7][31:0] START_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_CONST = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  // Model of the message state.
  logic [7:0]    blk_buf [64];
  logic [5:0]    blk_fill;
  logic [63:0]   msg_bytes;
  logic [31:0]   hash_state [8];
  digest_entry_t digest_q [$];
  int            n_fail;
  int            n_checked;
  int            n_digests;
  int            n_blocks;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Start a new message from the initial hash value.
  task automatic clear_message();
    blk_fill  = '0;
    msg_bytes = '0;
    for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
  endtask

  // One 64-round compression of the full block buffer into the hash state.
  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] wv [8];
    logic [31:0] wt, s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    end
    for (int j = 0; j < 8; j++) wv[j] = hash_state[j];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        s0 = rotr(w[(t-15) & 15], 7) ^ rotr(w[(t-15) & 15], 18) ^ (w[(t-15) & 15] >> 3);
        s1 = rotr(w[(t-2) & 15], 17) ^ rotr(w[(t-2) & 15], 19) ^ (w[(t-2) & 15] >> 10);
        wt = w[t & 15] + s0 + w[(t-7) & 15] + s1;
        w[t & 15] = wt;
      end
      t1 = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25)) +
           ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + ROUND_CONST[t] + wt;
      t2 = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22)) +
           ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
      for (int j = 7; j > 0; j--) wv[j] = wv[j-1];
      wv[4] = wv[4] + t1;
      wv[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_state[j] = hash_state[j] + wv[j];
    n_blocks++;
  endtask

  // Append one byte to the block, compressing when it becomes full.
  task automatic absorb_byte(input logic [7:0] b);
    blk_buf[blk_fill] = b;
    if (blk_fill == 6'd63) begin
      blk_fill = '0;
      compress_block();
    end else begin
      blk_fill = blk_fill + 6'd1;
    end
  endtask

  // Pad the message, run the last compressions and queue the digest words.
  task automatic finish_message();
    logic [63:0] bit_len;
    bit_len = msg_bytes << 3;
    absorb_byte(8'h80);
    while (blk_fill != 6'd56) absorb_byte(8'h00);
    for (int k = 0; k < 8; k++) absorb_byte(bit_len[63 - 8*k -: 8]);
    for (int k = 0; k < 8; k++) begin
      digest_q.push_back('{word: hash_state[k], index: 3'(k), last: (k == 7)});
    end
    n_digests++;
    clear_message();
  endtask

  // Compare one returned digest word with the oldest expected one.
  task automatic check_word();
    digest_entry_t exp_w;
    if (digest_q.size() == 0) begin
      $display("%0t: digest word with none expected: expected nothing, actual %h idx %0d",
               $time, digest_word, word_index);
      n_fail++;
    end else begin
      exp_w = digest_q.pop_front();
      n_checked++;
      if (digest_word !== exp_w.word) begin
        $display("%0t: digest_word mismatch: expected %h, actual %h",
                 $time, exp_w.word, digest_word);
        n_fail++;
      end
      if (word_index !== exp_w.index) begin
        $display("%0t: word_index mismatch: expected %0d, actual %0d",
                 $time, exp_w.index, word_index);
        n_fail++;
      end
      if (last_word !== exp_w.last) begin
        $display("%0t: last_word mismatch: expected %b, actual %b",
                 $time, exp_w.last, last_word);
        n_fail++;
      end
    end
  endtask

  // Follow both channels at every clock edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_message();
      digest_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (opcode == shbs_pkg::OP_FINISH) begin
          finish_message();
        end else begin
          absorb_byte(data_byte);
          msg_bytes = msg_bytes + 64'd1;
        end
      end
      if (out_valid && out_ready) check_word();
    end
    fail_count    <= n_fail;
    pending_words <= digest_q.size();
    words_checked <= n_checked;
    digests_done  <= n_digests;
    blocks_hashed <= n_blocks;
  end

  initial begin
    n_fail    = 0;
    n_checked = 0;
    n_digests = 0;
    n_blocks  = 0;
    clear_message();
  end

endmodule

// ===== test/sha256_byte_stream_hasher_unit_test.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Feeds byte messages and finish requests with random gaps and output stalls,
// including padding boundary lengths and a long receiver hold-off, and lets
// the checker compare every digest word with its own SHA-256 model.
// ----------------------------------------------------------------------------

module sha256_byte_stream_hasher_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_ABSORB  = ~shbs_pkg::OP_FINISH;
  localparam int   RAND_ITEMS = 220;
  localparam int   MIN_DIGESTS = 3;
  localparam int   HOLD_CYCLES = 400;

  // Message lengths around the one-block and two-block padding boundary.
  localparam logic [0:5][7:0] EDGE_LEN = {8'd55, 8'd56, 8'd57, 8'd63, 8'd64, 8'd65};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  int fail_count;
  int pending_words;
  int words_checked;
  int digests_done;
  int blocks_hashed;

  // Shared between the two drivers, apart from longest_msg.
  logic steady;
  logic hold_req;
  int   longest_msg;

  sha256_byte_stream_hasher_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  sha256_byte_stream_hasher_unit_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .digest_word   (digest_word),
    .word_index    (word_index),
    .last_word     (last_word),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .words_checked (words_checked),
    .digests_done  (digests_done),
    .blocks_hashed (blocks_hashed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one request after a random gap and wait until it is taken.
  task automatic send_req(input logic op, input logic [7:0] b);
    while (!steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // A whole message of random bytes followed by its finish request.
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_req(OP_ABSORB, 8'($urandom));
    send_req(shbs_pkg::OP_FINISH, 8'($urandom));
    if (len > longest_msg) longest_msg = len;
  endtask

  // Mostly short messages and padding boundary lengths, some longer ones.
  function automatic int pick_length();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return $urandom_range(8);
    if (sel < 8) return int'(EDGE_LEN[$urandom_range(5)]);
    return $urandom_range(130);
  endfunction

  // Receiver: random stalls, one long hold-off when asked for.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && out_valid) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 29);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int items;
    int len;
    int rand_digests;
    steady      = 1'b0;
    hold_req    = 1'b0;
    longest_msg = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    opcode    <= OP_ABSORB;
    data_byte <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty message, with the ignored data bits all ones.
    send_req(shbs_pkg::OP_FINISH, 8'hff);
    // The classic three-byte message.
    send_req(OP_ABSORB, 8'h61);
    send_req(OP_ABSORB, 8'h62);
    send_req(OP_ABSORB, 8'h63);
    send_req(shbs_pkg::OP_FINISH, 8'h00);
    // Single bytes at the extremes of the data field, then a two-byte message.
    send_req(OP_ABSORB, 8'h00);
    send_req(shbs_pkg::OP_FINISH, 8'h00);
    send_req(OP_ABSORB, 8'hff);
    send_req(shbs_pkg::OP_FINISH, 8'hff);
    send_req(OP_ABSORB, 8'h55);
    send_req(OP_ABSORB, 8'haa);
    send_req(shbs_pkg::OP_FINISH, 8'h5a);
    // Back-to-back finishes: each one restarts from the initial hash.
    send_req(shbs_pkg::OP_FINISH, 8'ha5);
    send_req(shbs_pkg::OP_FINISH, 8'h00);
    if (longest_msg < 3) longest_msg = 3;

    // Random messages; one stretch with no idling, one long output hold-off.
    items = 0;
    rand_digests = 0;
    while (items < RAND_ITEMS || rand_digests < MIN_DIGESTS) begin
      len = pick_length();
      steady = (items >= 80 && items < 150);
      if (rand_digests == 2) hold_req = 1'b1;
      send_message(len);
      items = items + len + 1;
      rand_digests++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain the remaining digest words, then let the block settle.
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Hashed %0d messages up to %0d bytes long in %0d blocks, %0d digest words checked,",
             digests_done, longest_msg, blocks_hashed, words_checked);
    $display("with empty messages, padding boundary lengths, random stalls and a long hold-off.");
    if (fail_count == 0) begin
      $display("** sha256_byte_stream_hasher_unit: PASSED **");
    end else begin
      $display("** sha256_byte_stream_hasher_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Timeout waiting for the hasher.");
    $display("** sha256_byte_stream_hasher_unit: FAILED **");
    $finish;
  end

endmodule
